[hdl/sacn_rx_pkg.sv]
// Package for the sACN universe receiver: field widths, packet layout offsets,
// status and opcode codes, and the constant byte tables of the packet header.
// No dependencies.
`timescale 1ns / 1ps

package sacn_rx_pkg;

  localparam int unsigned CountW     = 10;
  localparam int unsigned CountMax   = 1023;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned StatusW    = 3;

  localparam int unsigned DefSlotCount   = 513;
  localparam int unsigned DefPacketBytes = 638;

  localparam int unsigned RootIdAt     = 4;
  localparam int unsigned RootIdLen    = 12;
  localparam int unsigned FrameVecAt   = 40;
  localparam int unsigned FrameVecLen  = 4;
  localparam int unsigned DmpTypeAt    = 118;
  localparam logic [7:0]  DmpTypeValue = 8'hA1;
  localparam int unsigned SlotsAt      = 125;
  localparam logic [7:0]  StartCode    = 8'h00;

  typedef enum logic [StatusW-1:0] {
    StBadLength = 3'd0,
    StNotRoot   = 3'd1,
    StNotFrame  = 3'd2,
    StNotDmp    = 3'd3,
    StNotDmx    = 3'd4,
    StUnchanged = 3'd5,
    StNew       = 3'd6,
    StNone      = 3'd7
  } status_e;

  typedef enum logic {
    OpPacket = 1'b0,
    OpRead   = 1'b1
  } opcode_e;

  typedef enum logic {
    KindStatus = 1'b0,
    KindSlot   = 1'b1
  } kind_e;

  function automatic logic [7:0] root_id_byte(input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = 8'h41;
      4'd1:    b = 8'h53;
      4'd2:    b = 8'h43;
      4'd3:    b = 8'h2D;
      4'd4:    b = 8'h45;
      4'd5:    b = 8'h31;
      4'd6:    b = 8'h2E;
      4'd7:    b = 8'h31;
      4'd8:    b = 8'h37;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] frame_vec_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd3:    b = 8'h02;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[hdl/sacn_rx_in_if.sv]
// Input channel of the sACN receiver: packet bytes and slot read requests.
// Depends on sacn_rx_pkg for field widths.
`timescale 1ns / 1ps

interface sacn_rx_in_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic [sacn_rx_pkg::ByteW-1:0]     data_byte;
  logic                              last_byte;
  logic [sacn_rx_pkg::CountW-1:0]    slot_index;

  modport source (output valid, opcode, data_byte, last_byte, slot_index, input ready);
  modport sink   (input valid, opcode, data_byte, last_byte, slot_index, output ready);
endinterface

[hdl/sacn_rx_out_if.sv]
// Output channel of the sACN receiver: packet status and slot read data.
// Depends on sacn_rx_pkg for field widths.
`timescale 1ns / 1ps

interface sacn_rx_out_if;
  logic                              valid;
  logic                              ready;
  logic                              result_kind;
  logic [sacn_rx_pkg::StatusW-1:0]   status;
  logic [sacn_rx_pkg::ByteW-1:0]     slot_value;
  logic                              packet_valid;
  logic                              new_data;

  modport source (output valid, result_kind, status, slot_value, packet_valid, new_data,
                  input ready);
  modport sink   (input valid, result_kind, status, slot_value, packet_valid, new_data,
                  output ready);
endinterface

[hdl/sacn_dmx_universe_receiver.sv]
// Channel   | Dir | Payload                                              | Handshake
// in_i      | in  | opcode, data_byte, last_byte, slot_index             | valid/ready
// out_o     | out | result_kind, status, slot_value, packet_valid, new_data | valid/ready
//
// One word per cycle in while ready is high; results pass read stage and output register.
// Ready drops while the read stage holds a packet's last byte, as the bank swap settles.
// After reset both slot banks (2*SLOT_COUNT entries, 1026 by default) are
// zeroed one entry per cycle through the RAM write port; ready stays low meanwhile.
// An output register holds a result under backpressure; the read stage stalls behind it.
// Depends on sacn_rx_pkg, sacn_rx_in_if, sacn_rx_out_if and sacn_rx_ram.
`timescale 1ns / 1ps

module sacn_dmx_universe_receiver #(
  parameter int unsigned SLOT_COUNT   = sacn_rx_pkg::DefSlotCount,
  parameter int unsigned PACKET_BYTES = sacn_rx_pkg::DefPacketBytes
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sacn_rx_in_if.sink    in_i,
  sacn_rx_out_if.source out_o
);

  import sacn_rx_pkg::*;

  localparam int unsigned Depth = 2 * SLOT_COUNT;
  localparam int unsigned AddrW = $clog2(Depth);

  // clearing pass
  logic             clr_busy_q, clr_busy_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;

  // packet state
  logic [CountW-1:0] count_q, count_d;
  status_e           fail_q, fail_d;
  logic              differ_q, differ_d;
  logic              bank_q, bank_d;

  // read stage
  logic              s2_valid_q, s2_valid_d;
  logic              s2_read_q;
  logic              s2_last_q;
  logic [ByteW-1:0]  s2_data_q;
  logic              s2_slot_q;
  status_e           s2_code_q;
  logic              s2_len_ok_q;
  logic              s2_in_range_q;

  // output register
  logic              out_valid_q, out_valid_d;
  kind_e             out_kind_q;
  status_e           out_status_q;
  logic [ByteW-1:0]  out_value_q;
  logic              out_pvalid_q;
  logic              out_new_q;

  // stage 1 signals
  logic              accept;
  logic              is_pkt;
  logic [CountW-1:0] p;
  logic [CountW-1:0] slot_off;
  logic [CountW-1:0] root_off;
  logic [CountW-1:0] frame_off;
  logic              is_slot;
  logic              in_range;
  logic [CountW-1:0] count_inc;
  logic              len_ok;
  logic [ByteW-1:0]  expected;
  logic              check;
  status_e           check_code;
  status_e           code;
  logic [AddrW-1:0]  commit_base;
  logic [AddrW-1:0]  shadow_base;
  logic [AddrW-1:0]  rd_addr;
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [ByteW-1:0]  ram_wdata;
  logic [ByteW-1:0]  ram_rdata;

  // stage 2 signals
  logic              s2_pkt;
  logic              s2_has_res;
  logic              s2_adv;
  status_e           fail_eff;
  logic              differ_eff;
  status_e           pkt_status;

  assign p         = count_q;
  assign slot_off  = p - CountW'(SlotsAt);
  assign root_off  = p - CountW'(RootIdAt);
  assign frame_off = p - CountW'(FrameVecAt);
  assign is_slot   = (p >= CountW'(SlotsAt)) && (p < CountW'(SlotsAt + SLOT_COUNT));
  assign in_range  = (in_i.slot_index < CountW'(SLOT_COUNT));
  assign count_inc = (p < CountW'(CountMax)) ? p + CountW'(1) : CountW'(CountMax);
  assign len_ok    = (count_inc == CountW'(PACKET_BYTES));
  assign is_pkt    = (opcode_e'(in_i.opcode) == OpPacket);

  always_comb begin
    check      = 1'b0;
    expected   = StartCode;
    check_code = StNone;
    if (p >= CountW'(RootIdAt) && p < CountW'(RootIdAt + RootIdLen)) begin
      check      = 1'b1;
      expected   = root_id_byte(root_off[3:0]);
      check_code = StNotRoot;
    end else if (p >= CountW'(FrameVecAt) && p < CountW'(FrameVecAt + FrameVecLen)) begin
      check      = 1'b1;
      expected   = frame_vec_byte(frame_off[1:0]);
      check_code = StNotFrame;
    end else if (p == CountW'(DmpTypeAt)) begin
      check      = 1'b1;
      expected   = DmpTypeValue;
      check_code = StNotDmp;
    end else if (p == CountW'(SlotsAt)) begin
      check      = 1'b1;
      expected   = StartCode;
      check_code = StNotDmx;
    end
    code = (check && (in_i.data_byte != expected)) ? check_code : StNone;
  end

  assign commit_base = bank_q ? AddrW'(SLOT_COUNT) : '0;
  assign shadow_base = bank_q ? '0 : AddrW'(SLOT_COUNT);

  always_comb begin
    if (!is_pkt) begin
      rd_addr = commit_base + (in_range ? AddrW'(in_i.slot_index) : '0);
    end else begin
      rd_addr = commit_base + (is_slot ? AddrW'(slot_off) : '0);
    end
  end

  always_comb begin
    if (clr_busy_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = accept && is_pkt && is_slot;
      ram_waddr = shadow_base + AddrW'(slot_off);
      ram_wdata = in_i.data_byte;
    end
  end

  sacn_rx_ram #(
    .Width (ByteW),
    .Depth (Depth)
  ) u_banks (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign s2_pkt     = s2_valid_q && !s2_read_q;
  assign s2_has_res = s2_valid_q && (s2_read_q || s2_last_q);
  assign s2_adv     = s2_valid_q && (!s2_has_res || !out_valid_q || out_o.ready);
  assign fail_eff   = (fail_q == StNone) ? s2_code_q : fail_q;
  assign differ_eff = differ_q || (s2_slot_q && (ram_rdata != s2_data_q));

  always_comb begin
    if (!s2_len_ok_q) begin
      pkt_status = StBadLength;
    end else if (fail_eff != StNone) begin
      pkt_status = fail_eff;
    end else if (differ_eff) begin
      pkt_status = StNew;
    end else begin
      pkt_status = StUnchanged;
    end
  end

  // hold off while the read stage holds a packet's last byte: the bank may swap
  assign in_i.ready = !clr_busy_q && !(s2_valid_q && !s2_adv) && !(s2_pkt && s2_last_q);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    clr_busy_d  = clr_busy_q;
    clr_addr_d  = clr_addr_q;
    count_d     = count_q;
    fail_d      = fail_q;
    differ_d    = differ_q;
    bank_d      = bank_q;
    s2_valid_d  = s2_valid_q;
    out_valid_d = out_valid_q;

    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(Depth - 1)) begin
        clr_busy_d = 1'b0;
      end
    end

    if (accept && is_pkt) begin
      count_d = in_i.last_byte ? '0 : count_inc;
    end

    if (s2_adv && s2_pkt) begin
      if (s2_last_q) begin
        fail_d   = StNone;
        differ_d = 1'b0;
        if (pkt_status == StNew) begin
          bank_d = !bank_q;
        end
      end else begin
        fail_d   = fail_eff;
        differ_d = differ_eff;
      end
    end

    if (accept) begin
      s2_valid_d = 1'b1;
    end else if (s2_adv) begin
      s2_valid_d = 1'b0;
    end

    if (s2_adv && s2_has_res) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      count_q     <= '0;
      fail_q      <= StNone;
      differ_q    <= 1'b0;
      bank_q      <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_busy_q  <= clr_busy_d;
      clr_addr_q  <= clr_addr_d;
      count_q     <= count_d;
      fail_q      <= fail_d;
      differ_q    <= differ_d;
      bank_q      <= bank_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_read_q     <= !is_pkt;
      s2_last_q     <= in_i.last_byte;
      s2_data_q     <= in_i.data_byte;
      s2_slot_q     <= is_pkt && is_slot;
      s2_code_q     <= code;
      s2_len_ok_q   <= len_ok;
      s2_in_range_q <= in_range;
    end
    if (s2_adv && s2_has_res) begin
      if (s2_read_q) begin
        out_kind_q   <= KindSlot;
        out_status_q <= StBadLength;
        out_value_q  <= s2_in_range_q ? ram_rdata : '0;
        out_pvalid_q <= 1'b0;
        out_new_q    <= 1'b0;
      end else begin
        out_kind_q   <= KindStatus;
        out_status_q <= pkt_status;
        out_value_q  <= '0;
        out_pvalid_q <= (pkt_status == StNew) || (pkt_status == StUnchanged);
        out_new_q    <= (pkt_status == StNew);
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_kind  = out_kind_q;
  assign out_o.status       = out_status_q;
  assign out_o.slot_value   = out_value_q;
  assign out_o.packet_valid = out_pvalid_q;
  assign out_o.new_data     = out_new_q;

endmodule

[hdl/sacn_rx_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module sacn_rx_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1026
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sim/sacn_dmx_universe_receiver_checker.sv]
// Scoreboard for the sACN universe receiver: tracks the header checks, the slot banks and
// the bank swap, and compares every result word in order.
// Depends on sacn_rx_pkg, sacn_rx_in_if and sacn_rx_out_if.
`timescale 1ns / 1ps

module sacn_dmx_universe_receiver_checker #(
  parameter int unsigned SLOT_COUNT   = sacn_rx_pkg::DefSlotCount,
  parameter int unsigned PACKET_BYTES = sacn_rx_pkg::DefPacketBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sacn_rx_in_if       in_i,
  sacn_rx_out_if      out_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);
  import sacn_rx_pkg::*;

  localparam logic [95:0] RootTag  = {"ASC-E1.17", 24'h000000};
  localparam logic [31:0] FrameTag = 32'h0000_0002;

  typedef struct packed {
    kind_e      kind;
    status_e    status;
    logic [7:0] slot_value;
    logic       packet_valid;
    logic       new_data;
  } universe_reply_t;

  universe_reply_t universe_replies[$];

  int unsigned word_offset;
  status_e     first_fault;
  logic        slots_changed;
  logic        live_bank;
  logic [7:0]  slot_store [2*SLOT_COUNT];

  function automatic void note_fault(input status_e code);
    if (first_fault == StNone) first_fault = code;
  endfunction

  function automatic void advance_universe(input opcode_e op, input logic [7:0] data,
                                           input logic last, input logic [9:0] idx);
    universe_reply_t reply;
    int unsigned     pos;
    int unsigned     live_at;
    int unsigned     shadow_at;
    reply = '0;
    if (op == OpRead) begin
      reply.kind = KindSlot;
      if (idx < SLOT_COUNT) reply.slot_value = slot_store[(live_bank ? SLOT_COUNT : 0) + idx];
      universe_replies.push_back(reply);
      return;
    end
    pos = word_offset;
    if (pos >= RootIdAt && pos < RootIdAt + RootIdLen) begin
      if (data != RootTag[8*(RootIdLen-1-(pos-RootIdAt)) +: 8]) note_fault(StNotRoot);
    end else if (pos >= FrameVecAt && pos < FrameVecAt + FrameVecLen) begin
      if (data != FrameTag[8*(FrameVecLen-1-(pos-FrameVecAt)) +: 8]) note_fault(StNotFrame);
    end else if (pos == DmpTypeAt) begin
      if (data != DmpTypeValue) note_fault(StNotDmp);
    end
    if (pos == SlotsAt && data != StartCode) note_fault(StNotDmx);
    if (pos >= SlotsAt && pos - SlotsAt < SLOT_COUNT) begin
      live_at   = (live_bank ? SLOT_COUNT : 0) + (pos - SlotsAt);
      shadow_at = (live_bank ? 0 : SLOT_COUNT) + (pos - SlotsAt);
      if (slot_store[live_at] != data) slots_changed = 1'b1;
      slot_store[shadow_at] = data;
    end
    word_offset = (pos < CountMax) ? pos + 1 : CountMax;
    if (!last) return;
    reply.kind = KindStatus;
    if (word_offset != PACKET_BYTES) begin
      reply.status = StBadLength;
    end else if (first_fault != StNone) begin
      reply.status = first_fault;
    end else if (slots_changed) begin
      reply.status       = StNew;
      reply.packet_valid = 1'b1;
      reply.new_data     = 1'b1;
      live_bank          = ~live_bank;
    end else begin
      reply.status       = StUnchanged;
      reply.packet_valid = 1'b1;
    end
    word_offset   = 0;
    first_fault   = StNone;
    slots_changed = 1'b0;
    universe_replies.push_back(reply);
  endfunction

  function automatic void compare_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
      mismatches_o++;
    end
  endfunction

  function automatic void check_reply();
    universe_reply_t want;
    if (universe_replies.size() == 0) begin
      $error("unexpected result word: kind %0h status %0h slot %0h",
             out_i.result_kind, out_i.status, out_i.slot_value);
      mismatches_o++;
      return;
    end
    want = universe_replies.pop_front();
    compare_field("result_kind", want.kind, out_i.result_kind);
    compare_field("status", want.status, out_i.status);
    compare_field("slot_value", want.slot_value, out_i.slot_value);
    compare_field("packet_valid", want.packet_valid, out_i.packet_valid);
    compare_field("new_data", want.new_data, out_i.new_data);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_offset   = 0;
      first_fault   = StNone;
      slots_changed = 1'b0;
      live_bank     = 1'b0;
      for (int i = 0; i < 2*SLOT_COUNT; i++) slot_store[i] = 8'h00;
      universe_replies.delete();
      mismatches_o  = 0;
      pending_o     = 0;
    end else begin
      if (out_i.valid && out_i.ready) check_reply();
      if (in_i.valid && in_i.ready) begin
        advance_universe(opcode_e'(in_i.opcode), in_i.data_byte, in_i.last_byte,
                         in_i.slot_index);
      end
      pending_o = universe_replies.size();
    end
  end

endmodule

[sim/sacn_dmx_universe_receiver_test.sv]
// Testbench top for the sACN universe receiver: clock, reset, packet and slot read
// stimulus with random idling and backpressure, and the final verdict.
// Depends on sacn_rx_pkg, both channel interfaces, the block and its checker.
`timescale 1ns / 1ps

module sacn_dmx_universe_receiver_test;
  import sacn_rx_pkg::*;

  localparam int unsigned SLOT_COUNT    = DefSlotCount;
  localparam int unsigned PACKET_BYTES  = DefPacketBytes;
  localparam int unsigned MaxPacket     = 1100;
  localparam int unsigned IdlePercent   = 33;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned SettleCycles  = 20;
  localparam int unsigned RandomWords   = 700;
  localparam int unsigned RandomReplies = 48;
  localparam int unsigned RandomGood    = 6;

  localparam logic [3:0] FlawRoot  = 4'b0001;
  localparam logic [3:0] FlawFrame = 4'b0010;
  localparam logic [3:0] FlawDmp   = 4'b0100;
  localparam logic [3:0] FlawStart = 4'b1000;

  typedef enum logic [1:0] {
    SlotsSame,
    SlotsFew,
    SlotsRandom,
    SlotsExtreme
  } slot_fill_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned mismatches;
  int unsigned pending;
  logic        calm;
  int unsigned holdoff_requests;
  int unsigned cycle_count = 0;
  int unsigned words_sent, reads_sent, packets_sent, good_packets;
  logic [7:0]  pkt [MaxPacket];
  logic [7:0]  committed_copy [SLOT_COUNT];

  sacn_rx_in_if  word_in ();
  sacn_rx_out_if word_out ();

  sacn_dmx_universe_receiver #(
    .SLOT_COUNT  (SLOT_COUNT),
    .PACKET_BYTES(PACKET_BYTES)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (word_in),
    .out_o (word_out)
  );

  sacn_dmx_universe_receiver_checker #(
    .SLOT_COUNT  (SLOT_COUNT),
    .PACKET_BYTES(PACKET_BYTES)
  ) universe_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (word_in),
    .out_i       (word_out),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : sink_side
    int unsigned served;
    int unsigned left;
    served = 0;
    left   = 0;
    word_out.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (served != holdoff_requests) begin
        served = holdoff_requests;
        left   = HoldOffCycles;
      end
      if (left != 0) begin
        left--;
        word_out.ready <= 1'b0;
      end else begin
        word_out.ready <= calm || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  task automatic send_word(input opcode_e op, input logic [7:0] data, input logic last,
                           input logic [9:0] idx);
    while (!calm && $urandom_range(99) < IdlePercent) begin
      word_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    word_in.valid      <= 1'b1;
    word_in.opcode     <= op;
    word_in.data_byte  <= data;
    word_in.last_byte  <= last;
    word_in.slot_index <= idx;
    do @(posedge clk_i); while (!word_in.ready);
    @(negedge clk_i);
    words_sent++;
  endtask

  function automatic logic [9:0] pick_slot();
    return ($urandom_range(99) < 85) ? 10'($urandom_range(SLOT_COUNT - 1)) : 10'($urandom);
  endfunction

  task automatic send_read(input logic [9:0] idx);
    send_word(OpRead, 8'($urandom), 1'($urandom), idx);
    reads_sent++;
  endtask

  task automatic send_packet(input int unsigned len, input logic [3:0] flaws,
                             input slot_fill_e fill, input int unsigned read_pct);
    int unsigned pick;
    for (int i = 0; i < MaxPacket; i++) pkt[i] = 8'($urandom);
    for (int i = 0; i < RootIdLen; i++) pkt[RootIdAt + i] = root_id_byte(4'(i));
    for (int i = 0; i < FrameVecLen; i++) pkt[FrameVecAt + i] = frame_vec_byte(2'(i));
    pkt[DmpTypeAt] = DmpTypeValue;
    pkt[SlotsAt]   = StartCode;
    for (int s = 1; s < SLOT_COUNT; s++) begin
      case (fill)
        SlotsSame, SlotsFew: pkt[SlotsAt + s] = committed_copy[s];
        SlotsExtreme:        pkt[SlotsAt + s] = s[0] ? 8'hFF : 8'h00;
        default:             ;
      endcase
    end
    if (fill == SlotsFew) begin
      repeat (3) begin
        pick = $urandom_range(SLOT_COUNT - 1, 1);
        pkt[SlotsAt + pick] ^= 8'($urandom_range(255, 1));
      end
    end
    if ((flaws & FlawRoot) != 0)
      pkt[RootIdAt + $urandom_range(RootIdLen - 1)] ^= 8'($urandom_range(255, 1));
    if ((flaws & FlawFrame) != 0)
      pkt[FrameVecAt + $urandom_range(FrameVecLen - 1)] ^= 8'($urandom_range(255, 1));
    if ((flaws & FlawDmp) != 0) pkt[DmpTypeAt] ^= 8'($urandom_range(255, 1));
    if ((flaws & FlawStart) != 0) pkt[SlotsAt] = 8'($urandom_range(255, 1));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < read_pct) send_read(pick_slot());
      send_word(OpPacket, pkt[i], i == len - 1, 10'($urandom));
    end
    packets_sent++;
    if (len == PACKET_BYTES && flaws == 4'b0000) begin
      good_packets++;
      for (int s = 0; s < SLOT_COUNT; s++) committed_copy[s] = pkt[SlotsAt + s];
    end
  endtask

  task automatic drain();
    word_in.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin : source_side
    int unsigned round;
    int unsigned base_words, base_replies, base_good;
    int unsigned len, dice;
    logic [3:0]  flaws;
    rst_ni             = 1'b0;
    calm               = 1'b0;
    holdoff_requests   = 0;
    words_sent         = 0;
    reads_sent         = 0;
    packets_sent       = 0;
    good_packets       = 0;
    word_in.valid      = 1'b0;
    word_in.opcode     = OpPacket;
    word_in.data_byte  = 8'h00;
    word_in.last_byte  = 1'b0;
    word_in.slot_index = 10'd0;
    for (int s = 0; s < SLOT_COUNT; s++) committed_copy[s] = 8'h00;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_read(10'd0);
    send_read(10'(SLOT_COUNT - 1));
    send_read(10'(SLOT_COUNT));
    send_read(10'h3FF);
    send_packet(PACKET_BYTES, 4'b0000, SlotsExtreme, 0);
    send_read(10'd1);
    send_read(10'(SLOT_COUNT - 1));
    send_packet(PACKET_BYTES, 4'b0000, SlotsSame, 0);
    send_packet(PACKET_BYTES, FlawRoot, SlotsRandom, 0);
    send_packet(PACKET_BYTES, FlawFrame, SlotsRandom, 0);
    send_packet(PACKET_BYTES, FlawDmp, SlotsFew, 0);
    send_packet(PACKET_BYTES, FlawStart, SlotsSame, 0);
    send_packet(PACKET_BYTES, FlawRoot | FlawDmp, SlotsRandom, 0);
    send_packet(PACKET_BYTES, FlawFrame | FlawStart, SlotsRandom, 0);
    send_packet(PACKET_BYTES - 1, 4'b0000, SlotsFew, 0);
    send_packet(PACKET_BYTES + 1, 4'b0000, SlotsFew, 0);
    send_packet(1, 4'b0000, SlotsRandom, 0);
    send_packet(200, FlawRoot, SlotsRandom, 0);
    send_packet(MaxPacket, 4'b0000, SlotsSame, 0);
    send_packet(PACKET_BYTES, 4'b0000, SlotsFew, 5);
    send_read(10'd2);

    // wait out every result, then stall the receiver while reads pile up
    drain();
    holdoff_requests++;
    repeat (40) send_read(pick_slot());

    base_words   = words_sent;
    base_replies = reads_sent + packets_sent;
    base_good    = good_packets;
    round        = 0;
    while (words_sent - base_words < RandomWords
           || reads_sent + packets_sent - base_replies < RandomReplies
           || good_packets - base_good < RandomGood) begin
      calm = (round >= 4 && round < 10);
      if (round == 3) drain();
      dice  = $urandom_range(99);
      flaws = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 1)) : 4'b0000;
      if (dice < 55) begin
        send_packet(PACKET_BYTES, flaws, slot_fill_e'($urandom_range(3)), 2);
      end else if (dice < 75) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(PACKET_BYTES + 3, PACKET_BYTES - 3)
                                       : $urandom_range(160, 1);
        if (len == PACKET_BYTES) len++;
        send_packet(len, flaws, slot_fill_e'($urandom_range(3)), 2);
      end else begin
        repeat ($urandom_range(8, 1)) send_read(pick_slot());
      end
      round++;
    end
    calm = 1'b0;

    drain();
    repeat (SettleCycles) @(negedge clk_i);
    $display("Sent %0d words: %0d packets (%0d well formed), %0d slot reads",
             words_sent, packets_sent, good_packets, reads_sent);
    $display("Included header faults, wrong and saturating lengths, receiver hold-off and drains");
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/sacn_rx_pkg.sv
hdl/sacn_rx_in_if.sv
hdl/sacn_rx_out_if.sv
hdl/sacn_rx_ram.sv
hdl/sacn_dmx_universe_receiver.sv
sim/sacn_dmx_universe_receiver_checker.sv
sim/sacn_dmx_universe_receiver_test.sv
